// ===== design/ahm_pkg.sv =====
// constants and types shared by the adaptive huffman model update block
`default_nettype none
package ahm_pkg;
   localparam int SYMBOL_COUNT = 314;
   localparam int NODE_COUNT   = 2 * SYMBOL_COUNT - 1;
   localparam int FREQ_DEPTH   = NODE_COUNT + 1;
   localparam int PARENT_DEPTH = NODE_COUNT + SYMBOL_COUNT;
   localparam int CHILD_DEPTH  = NODE_COUNT;

   localparam int SYM_W  = 9;
   localparam int NODE_W = 10;
   localparam int FREQ_W = 16;

   localparam logic [NODE_W-1:0] NODES     = NODE_W'(NODE_COUNT);
   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] PAR_END   = NODE_W'(PARENT_DEPTH);
   localparam logic [NODE_W-1:0] LAST_LEAF = NODE_W'(SYMBOL_COUNT - 1);
   localparam logic [NODE_W-1:0] FIRST_INT = NODE_W'(SYMBOL_COUNT);
   localparam logic [SYM_W-1:0]  SYMS      = SYM_W'(SYMBOL_COUNT);

   localparam logic [FREQ_W-1:0] STOP_COUNT      = 16'hFFFF;
   localparam logic [FREQ_W-1:0] THRESHOLD_RESET = 16'h8000;

   typedef enum logic [5:0] {
      ST_INIT_LEAF, ST_INIT_N0, ST_INIT_N1, ST_INIT_N2, ST_INIT_N3, ST_INIT_ROOT,
      ST_IDLE, ST_CHK0, ST_CHK1,
      ST_G0, ST_G1,
      ST_P0, ST_P1, ST_P2, ST_K0, ST_K1, ST_SH0, ST_SH1, ST_SHF,
      ST_L0, ST_L1, ST_L2, ST_L3,
      ST_W0, ST_W1, ST_WL, ST_WL1, ST_WL2, ST_SR0, ST_SR1,
      ST_SW0, ST_SW1, ST_SW2, ST_SW3, ST_SW4, ST_SW5, ST_SW6,
      ST_WP0, ST_WP1, ST_FIN0, ST_FIN1
   } state_type;
endpackage
`default_nettype wire

// ===== design/ahm_req_if.sv =====
// request channel carrying one symbol per transfer
`default_nettype none
interface ahm_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] symbol;
   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface
`default_nettype wire

// ===== design/ahm_rsp_if.sv =====
// response channel carrying one update result per transfer
`default_nettype none
interface ahm_rsp_if;
   logic        valid;
   logic        ready;
   logic        rebuilt;
   logic [9:0]  swap_count;
   logic [15:0] root_frequency;
   logic [9:0]  leaf_parent;
   modport source (output valid, output rebuilt, output swap_count,
                   output root_frequency, output leaf_parent, input ready);
   modport sink   (input valid, input rebuilt, input swap_count,
                   input root_frequency, input leaf_parent, output ready);
endinterface
`default_nettype wire

// ===== design/adaptive_huffman_model_update_core.sv =====
// adaptive huffman model update: tree tables with a sequenced update and rebuild
// an update increments each node on the path to the root and may exchange it after a search of the entries above it
// a rebuild halves the leaf frequencies, inserts each joined pair in sorted order, then relinks the parents
// one item at a time; each table memory has one write port and one registered read port
// reset: synchronous, builds the balanced initial tree
// before the first transfer is taken; threshold resets to 0x8000
`default_nettype none
module adaptive_huffman_model_update_core (
   input  wire logic  clock,
   input  wire logic  reset,
   ahm_req_if.sink    req_ch,
   ahm_rsp_if.source  rsp_ch,
   input  wire logic  csr_we,
   input  wire logic [ahm_pkg::FREQ_W-1:0] csr_wdata
);
   import ahm_pkg::*;

   logic [FREQ_W-1:0] freq_mem   [FREQ_DEPTH];
   logic [NODE_W-1:0] parent_mem [PARENT_DEPTH];
   logic [NODE_W-1:0] child_mem  [CHILD_DEPTH];

   logic freq_we, parent_we, child_we;
   logic [NODE_W-1:0] freq_wa, freq_ra, parent_wa, parent_ra, child_wa, child_ra;
   logic [FREQ_W-1:0] freq_wd;
   logic [NODE_W-1:0] parent_wd, child_wd;
   logic [FREQ_W-1:0] freq_q_ff;
   logic [NODE_W-1:0] parent_q_ff, child_q_ff;

   state_type state_ff, state_in;
   logic [NODE_W-1:0] i_ff, i_in, j_ff, j_in, p_ff, p_in, c_ff, c_in, l_ff, l_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in, steps_ff, steps_in, swaps_ff, swaps_in;
   logic [NODE_W:0]   k_ff, k_in;
   logic [FREQ_W-1:0] f_ff, f_in, thr_ff;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic rebuilt_ff, rebuilt_in, oor_ff, oor_in;
   logic rsp_valid_ff;
   logic rsp_rebuilt_ff;
   logic [NODE_W-1:0] rsp_swaps_ff, rsp_leaf_ff;
   logic [FREQ_W-1:0] rsp_root_ff;
   logic [NODE_W-1:0] sym_node;
   logic [FREQ_W-1:0] half_freq;

   assign sym_node  = NODE_W'({1'b0, sym_ff} + NODES);
   assign half_freq = FREQ_W'(({1'b0, freq_q_ff} + 17'd1) >> 1);

   always_ff @(posedge clock) begin
      if (freq_we) freq_mem[freq_wa] <= freq_wd;
      freq_q_ff <= freq_mem[freq_ra];
   end
   always_ff @(posedge clock) begin
      if (parent_we) parent_mem[parent_wa] <= parent_wd;
      parent_q_ff <= parent_mem[parent_ra];
   end
   always_ff @(posedge clock) begin
      if (child_we) child_mem[child_wa] <= child_wd;
      child_q_ff <= child_mem[child_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_LEAF: if (i_ff == LAST_LEAF) state_in = ST_INIT_N0;
         ST_INIT_N0:   state_in = ST_INIT_N1;
         ST_INIT_N1:   state_in = ST_INIT_N2;
         ST_INIT_N2:   state_in = ST_INIT_N3;
         ST_INIT_N3:   state_in = (j_ff == ROOT_NODE) ? ST_INIT_ROOT : ST_INIT_N0;
         ST_INIT_ROOT: state_in = ST_IDLE;
         ST_IDLE:      if (req_ch.valid && req_ch.ready) state_in = ST_CHK0;
         ST_CHK0:      state_in = ST_CHK1;
         ST_CHK1: begin
            if (sym_ff >= SYMS) state_in = ST_FIN0;
            else if (freq_q_ff == thr_ff) state_in = ST_G0;
            else state_in = ST_W0;
         end
         ST_G0:  state_in = ST_G1;
         ST_G1:  state_in = (i_ff == ROOT_NODE) ? ST_P0 : ST_G0;
         ST_P0:  state_in = ST_P1;
         ST_P1:  state_in = ST_P2;
         ST_P2:  state_in = ST_K0;
         ST_K0:  state_in = k_ff[NODE_W] ? ST_SH0 : ST_K1;
         ST_K1:  state_in = (f_ff < freq_q_ff) ? ST_K0 : ST_SH0;
         ST_SH0: state_in = (p_ff == k_ff[NODE_W-1:0]) ? ST_SHF : ST_SH1;
         ST_SH1: state_in = ST_SH0;
         ST_SHF: state_in = (j_ff == ROOT_NODE) ? ST_L0 : ST_P0;
         ST_L0:  state_in = ST_L1;
         ST_L1:  state_in = (child_q_ff < NODES) ? ST_L2 : ST_L3;
         ST_L2:  state_in = ST_L3;
         ST_L3:  state_in = (i_ff == ROOT_NODE) ? ST_W0 : ST_L0;
         ST_W0:  state_in = ST_W1;
         ST_W1:  state_in = ST_WL;
         ST_WL:  state_in = (steps_ff >= NODES || c_ff >= NODES) ? ST_FIN0 : ST_WL1;
         ST_WL1: state_in = ST_WL2;
         ST_WL2: state_in = (f_ff > freq_q_ff) ? ST_SR0 : ST_WP0;
         ST_SR0: state_in = (l_ff >= NODES) ? ST_SW0 : ST_SR1;
         ST_SR1: state_in = (f_ff > freq_q_ff) ? ST_SR0 : ST_SW0;
         ST_SW0: state_in = ST_SW1;
         ST_SW1: state_in = ST_SW2;
         ST_SW2: state_in = (a_ff < NODES) ? ST_SW3 : ST_SW4;
         ST_SW3: state_in = ST_SW4;
         ST_SW4: state_in = (b_ff < NODES) ? ST_SW5 : ST_SW6;
         ST_SW5: state_in = ST_SW6;
         ST_SW6: state_in = ST_WP0;
         ST_WP0: state_in = ST_WP1;
         ST_WP1: state_in = (parent_q_ff == '0) ? ST_FIN0 : ST_WL;
         ST_FIN0: state_in = ST_FIN1;
         ST_FIN1: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memory controls and datapath
   always_comb begin
      freq_we = 1'b0;   freq_wa = '0;   freq_wd = '0;   freq_ra = '0;
      parent_we = 1'b0; parent_wa = '0; parent_wd = '0; parent_ra = '0;
      child_we = 1'b0;  child_wa = '0;  child_wd = '0;  child_ra = '0;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; p_in = p_ff; c_in = c_ff; l_in = l_ff;
      a_in = a_ff; b_in = b_ff; f_in = f_ff; sym_in = sym_ff; oor_in = oor_ff;
      steps_in = steps_ff; swaps_in = swaps_ff; rebuilt_in = rebuilt_ff;
      unique case (state_ff)
         ST_INIT_LEAF: begin
            freq_we = 1'b1;   freq_wa = i_ff;  freq_wd = FREQ_W'(1);
            child_we = 1'b1;  child_wa = i_ff; child_wd = NODE_W'(i_ff + NODES);
            parent_we = 1'b1; parent_wa = NODE_W'(i_ff + NODES); parent_wd = i_ff;
            if (i_ff == LAST_LEAF) begin
               i_in = '0;
               j_in = FIRST_INT;
            end else begin
               i_in = NODE_W'(i_ff + 1'b1);
            end
         end
         ST_INIT_N0: freq_ra = i_ff;
         ST_INIT_N1: begin
            freq_ra = NODE_W'(i_ff + 1'b1);
            f_in = freq_q_ff;
         end
         ST_INIT_N2: begin
            freq_we = 1'b1;   freq_wa = j_ff;  freq_wd = FREQ_W'(f_ff + freq_q_ff);
            child_we = 1'b1;  child_wa = j_ff; child_wd = i_ff;
            parent_we = 1'b1; parent_wa = i_ff; parent_wd = j_ff;
         end
         ST_INIT_N3: begin
            parent_we = 1'b1; parent_wa = NODE_W'(i_ff + 1'b1); parent_wd = j_ff;
            i_in = NODE_W'(i_ff + 2'd2);
            j_in = NODE_W'(j_ff + 1'b1);
         end
         ST_INIT_ROOT: begin
            freq_we = 1'b1;   freq_wa = NODES;     freq_wd = STOP_COUNT;
            parent_we = 1'b1; parent_wa = ROOT_NODE; parent_wd = '0;
         end
         ST_IDLE: sym_in = req_ch.symbol;
         ST_CHK0: begin
            freq_ra = ROOT_NODE;
            rebuilt_in = 1'b0;
            swaps_in = '0;
            oor_in = (sym_ff >= SYMS);
         end
         ST_CHK1: begin
            if (!oor_ff && freq_q_ff == thr_ff) begin
               rebuilt_in = 1'b1;
               i_in = '0;
               j_in = '0;
            end
         end
         ST_G0: begin
            freq_ra = i_ff;
            child_ra = i_ff;
         end
         ST_G1: begin
            if (child_q_ff >= NODES) begin
               freq_we = 1'b1;  freq_wa = j_ff;  freq_wd = half_freq;
               child_we = 1'b1; child_wa = j_ff; child_wd = child_q_ff;
               j_in = NODE_W'(j_ff + 1'b1);
            end
            if (i_ff == ROOT_NODE) begin
               i_in = '0;
               j_in = FIRST_INT;
            end else begin
               i_in = NODE_W'(i_ff + 1'b1);
            end
         end
         ST_P0: freq_ra = i_ff;
         ST_P1: begin
            freq_ra = NODE_W'(i_ff + 1'b1);
            f_in = freq_q_ff;
         end
         ST_P2: begin
            f_in = FREQ_W'(f_ff + freq_q_ff);
            k_in = (NODE_W + 1)'({1'b0, j_ff} - 1'b1);
         end
         ST_K0: begin
            freq_ra = k_ff[NODE_W-1:0];
            if (k_ff[NODE_W]) begin
               k_in = (NODE_W + 1)'(k_ff + 1'b1);
               p_in = j_ff;
            end
         end
         ST_K1: begin
            if (f_ff < freq_q_ff) begin
               k_in = (NODE_W + 1)'(k_ff - 1'b1);
            end else begin
               k_in = (NODE_W + 1)'(k_ff + 1'b1);
               p_in = j_ff;
            end
         end
         ST_SH0: begin
            freq_ra = NODE_W'(p_ff - 1'b1);
            child_ra = NODE_W'(p_ff - 1'b1);
         end
         ST_SH1: begin
            freq_we = 1'b1;  freq_wa = p_ff;  freq_wd = freq_q_ff;
            child_we = 1'b1; child_wa = p_ff; child_wd = child_q_ff;
            p_in = NODE_W'(p_ff - 1'b1);
         end
         ST_SHF: begin
            freq_we = 1'b1;  freq_wa = k_ff[NODE_W-1:0];  freq_wd = f_ff;
            child_we = 1'b1; child_wa = k_ff[NODE_W-1:0]; child_wd = i_ff;
            if (j_ff == ROOT_NODE) begin
               i_in = '0;
            end else begin
               i_in = NODE_W'(i_ff + 2'd2);
               j_in = NODE_W'(j_ff + 1'b1);
            end
         end
         ST_L0: child_ra = i_ff;
         ST_L1: begin
            a_in = child_q_ff;
            if (child_q_ff < PAR_END) begin
               parent_we = 1'b1; parent_wa = child_q_ff; parent_wd = i_ff;
            end
         end
         ST_L2: begin
            parent_we = 1'b1; parent_wa = NODE_W'(a_ff + 1'b1); parent_wd = i_ff;
         end
         ST_L3: i_in = NODE_W'(i_ff + 1'b1);
         ST_W0: parent_ra = sym_node;
         ST_W1: begin
            c_in = parent_q_ff;
            steps_in = '0;
         end
         ST_WL: freq_ra = c_ff;
         ST_WL1: begin
            freq_ra = NODE_W'(c_ff + 1'b1);
            f_in = FREQ_W'(freq_q_ff + 1'b1);
         end
         ST_WL2: begin
            freq_we = 1'b1; freq_wa = c_ff; freq_wd = f_ff;
            l_in = NODE_W'(c_ff + 2'd2);
         end
         ST_SR0: begin
            freq_ra = l_ff;
            if (l_ff >= NODES) l_in = NODE_W'(l_ff - 1'b1);
         end
         ST_SR1: begin
            if (f_ff > freq_q_ff) l_in = NODE_W'(l_ff + 1'b1);
            else l_in = NODE_W'(l_ff - 1'b1);
         end
         ST_SW0: begin
            freq_ra = l_ff;
            child_ra = c_ff;
         end
         ST_SW1: begin
            freq_we = 1'b1; freq_wa = c_ff; freq_wd = freq_q_ff;
            a_in = child_q_ff;
            child_ra = l_ff;
         end
         ST_SW2: begin
            freq_we = 1'b1;  freq_wa = l_ff;  freq_wd = f_ff;
            b_in = child_q_ff;
            child_we = 1'b1; child_wa = l_ff; child_wd = a_ff;
            if (a_ff < PAR_END) begin
               parent_we = 1'b1; parent_wa = a_ff; parent_wd = l_ff;
            end
         end
         ST_SW3: begin
            parent_we = 1'b1; parent_wa = NODE_W'(a_ff + 1'b1); parent_wd = l_ff;
         end
         ST_SW4: begin
            child_we = 1'b1; child_wa = c_ff; child_wd = b_ff;
            if (b_ff < PAR_END) begin
               parent_we = 1'b1; parent_wa = b_ff; parent_wd = c_ff;
            end
         end
         ST_SW5: begin
            parent_we = 1'b1; parent_wa = NODE_W'(b_ff + 1'b1); parent_wd = c_ff;
         end
         ST_SW6: begin
            c_in = l_ff;
            swaps_in = NODE_W'(swaps_ff + 1'b1);
         end
         ST_WP0: parent_ra = c_ff;
         ST_WP1: begin
            if (parent_q_ff != '0) begin
               c_in = parent_q_ff;
               steps_in = NODE_W'(steps_ff + 1'b1);
            end
         end
         ST_FIN0: begin
            freq_ra = ROOT_NODE;
            parent_ra = oor_ff ? '0 : sym_node;
         end
         ST_FIN1: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_LEAF;
         i_ff         <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         if (csr_we) thr_ff <= csr_wdata;
         if (state_ff == ST_FIN1) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in; k_ff <= k_in; p_ff <= p_in; c_ff <= c_in; l_ff <= l_in;
      a_ff <= a_in; b_ff <= b_in; f_ff <= f_in; sym_ff <= sym_in; oor_ff <= oor_in;
      steps_ff <= steps_in; swaps_ff <= swaps_in; rebuilt_ff <= rebuilt_in;
      if (state_ff == ST_FIN1) begin
         rsp_rebuilt_ff <= rebuilt_ff;
         rsp_swaps_ff   <= swaps_ff;
         rsp_root_ff    <= freq_q_ff;
         rsp_leaf_ff    <= oor_ff ? '0 : parent_q_ff;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.rebuilt        = rsp_rebuilt_ff;
   assign rsp_ch.swap_count     = rsp_swaps_ff;
   assign rsp_ch.root_frequency = rsp_root_ff;
   assign rsp_ch.leaf_parent    = rsp_leaf_ff;
endmodule
`default_nettype wire

// ===== verif/adaptive_huffman_model_update_core_test.sv =====
// testbench for the adaptive huffman model update core: predicts each update and checks the results
`default_nettype none
module adaptive_huffman_model_update_core_test;
   import ahm_pkg::*;

   typedef struct {
      bit         rebuilt;
      bit [9:0]   swap_count;
      bit [15:0]  root_frequency;
      bit [9:0]   leaf_parent;
   } update_result_type;

   class huffman_scoreboard;
      bit [15:0] counts [0:FREQ_DEPTH-1];
      bit [9:0]  up_link [0:PARENT_DEPTH-1];
      bit [9:0]  down_link [0:CHILD_DEPTH-1];
      bit [15:0] threshold;
      update_result_type pending[$];
      int errors;
      int checked;
      int rebuilds;
      int swaps_seen;

      function void clear_tree();
         int i, j;
         for (i = 0; i < SYMBOL_COUNT; i++) begin
            counts[i] = 1;
            down_link[i] = 10'(i + NODE_COUNT);
            up_link[i + NODE_COUNT] = 10'(i);
         end
         for (i = 0, j = SYMBOL_COUNT; j <= NODE_COUNT - 1; i += 2, j++) begin
            counts[j] = counts[i] + counts[i + 1];
            down_link[j] = 10'(i);
            up_link[i] = 10'(j);
            up_link[i + 1] = 10'(j);
         end
         counts[NODE_COUNT] = STOP_COUNT;
         up_link[NODE_COUNT - 1] = 0;
         threshold = THRESHOLD_RESET;
      endfunction

      function void hook(int node, int value);
         if (node < NODE_COUNT) begin
            up_link[node] = 10'(value);
            up_link[node + 1] = 10'(value);
         end else if (node < PARENT_DEPTH) begin
            up_link[node] = 10'(value);
         end
      endfunction

      function void rebuild();
         int i, j, k, m;
         bit [15:0] f;
         j = 0;
         for (i = 0; i < NODE_COUNT; i++) begin
            if (down_link[i] >= NODE_COUNT && j < NODE_COUNT) begin
               counts[j] = 16'(({1'b0, counts[i]} + 17'd1) >> 1);
               down_link[j] = down_link[i];
               j++;
            end
         end
         for (i = 0, j = SYMBOL_COUNT; j < NODE_COUNT; i += 2, j++) begin
            f = counts[i] + counts[i + 1];
            counts[j] = f;
            k = j - 1;
            while (k >= 0 && f < counts[k]) k--;
            k++;
            for (m = j - k; m > 0; m--) begin
               counts[k + m] = counts[k + m - 1];
               down_link[k + m] = down_link[k + m - 1];
            end
            counts[k] = f;
            down_link[k] = 10'(i);
         end
         for (i = 0; i < NODE_COUNT; i++) hook(down_link[i], i);
         counts[NODE_COUNT] = STOP_COUNT;
      endfunction

      function update_result_type apply_symbol(bit [8:0] sym);
         update_result_type r;
         int c, l, a, b, steps;
         bit [15:0] k;
         r.rebuilt = 0;
         r.swap_count = 0;
         r.leaf_parent = 0;
         if (sym >= SYMBOL_COUNT) begin
            r.root_frequency = counts[NODE_COUNT - 1];
            return r;
         end
         if (counts[NODE_COUNT - 1] == threshold) begin
            rebuild();
            r.rebuilt = 1;
            rebuilds++;
         end
         c = up_link[sym + NODE_COUNT];
         for (steps = 0; steps < NODE_COUNT && c < NODE_COUNT; steps++) begin
            k = counts[c] + 16'd1;
            counts[c] = k;
            if (k > counts[c + 1]) begin
               l = c + 2;
               while (l < NODE_COUNT && k > counts[l]) l++;
               l--;
               counts[c] = counts[l];
               counts[l] = k;
               a = down_link[c];
               hook(a, l);
               b = down_link[l];
               down_link[l] = 10'(a);
               hook(b, c);
               down_link[c] = 10'(b);
               c = l;
               r.swap_count++;
            end
            c = up_link[c];
            if (c == 0) break;
         end
         swaps_seen += r.swap_count;
         r.root_frequency = counts[NODE_COUNT - 1];
         r.leaf_parent = up_link[sym + NODE_COUNT];
         return r;
      endfunction

      function void note_symbol(bit [8:0] sym);
         pending.push_back(apply_symbol(sym));
      endfunction

      function void check_update(update_result_type got);
         update_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected: rebuilt %0d swaps %0d root %0d leaf %0d",
                     $time, got.rebuilt, got.swap_count, got.root_frequency, got.leaf_parent);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.rebuilt !== exp.rebuilt) begin
            $display("%0t: rebuilt expected %0d actual %0d", $time, exp.rebuilt, got.rebuilt);
            errors++;
         end
         if (got.swap_count !== exp.swap_count) begin
            $display("%0t: swap_count expected %0d actual %0d",
                     $time, exp.swap_count, got.swap_count);
            errors++;
         end
         if (got.root_frequency !== exp.root_frequency) begin
            $display("%0t: root_frequency expected %0d actual %0d",
                     $time, exp.root_frequency, got.root_frequency);
            errors++;
         end
         if (got.leaf_parent !== exp.leaf_parent) begin
            $display("%0t: leaf_parent expected %0d actual %0d",
                     $time, exp.leaf_parent, got.leaf_parent);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [FREQ_W-1:0] csr_wdata;
   ahm_req_if req_ch();
   ahm_rsp_if rsp_ch();

   huffman_scoreboard tree_model;
   int symbols_sent;
   int out_of_range_sent;
   int stall_mode;
   int stall_left;
   int cycle_count;

   adaptive_huffman_model_update_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("timeout with %0d results outstanding", tree_model.pending.size());
      $display("** adaptive_huffman_model_update_core: FAILED **");
      $finish;
   end

   // accepted transfers on both channels
   always @(posedge clock) begin
      update_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) tree_model.note_symbol(req_ch.symbol);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.rebuilt = rsp_ch.rebuilt;
            got.swap_count = rsp_ch.swap_count;
            got.root_frequency = rsp_ch.root_frequency;
            got.leaf_parent = rsp_ch.leaf_parent;
            tree_model.check_update(got);
         end
      end
   end

   // receiver stall pattern, mode picked at random from time to time
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
      if (stall_mode == 0) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_ch.ready <= ($urandom_range(0, 1) == 1);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_left <= $urandom_range(0, 20);
         rsp_ch.ready <= 1'b1;
      end
   end

   int burst_left;

   task automatic send_symbol(input bit [8:0] sym);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.symbol <= sym;
      symbols_sent++;
      if (sym >= SYMBOL_COUNT) out_of_range_sent++;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (tree_model.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_threshold(input bit [15:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      tree_model.threshold = value;
   endtask

   task automatic send_random(input int count);
      int n, pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) send_symbol(9'($urandom_range(SYMBOL_COUNT, 511)));
         else if (pick < 55) send_symbol(9'($urandom_range(0, 7)));
         else send_symbol(9'($urandom_range(0, SYMBOL_COUNT - 1)));
      end
   endtask

   initial begin
      int n;
      tree_model = new();
      tree_model.clear_tree();
      cycle_count = 0;
      stall_mode = 0;
      stall_left = 0;
      burst_left = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.symbol = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, out of range symbols, repeated hits that force exchanges
      send_symbol(9'd0);
      send_symbol(9'(SYMBOL_COUNT - 1));
      send_symbol(9'(SYMBOL_COUNT));
      send_symbol(9'd511);
      send_symbol(9'd256);
      send_symbol(9'd1);
      for (n = 0; n < 6; n++) send_symbol(9'd5);
      for (n = 0; n < 8; n++) send_symbol(9'd300);
      wait_idle();

      write_threshold(tree_model.counts[NODE_COUNT - 1] + 16'd30);
      send_random(200);
      wait_idle();
      write_threshold(16'd2);
      send_random(150);
      wait_idle();
      write_threshold(16'd65534);
      send_random(150);
      wait_idle();
      write_threshold(tree_model.counts[NODE_COUNT - 1] + 16'd20);
      send_random(150);

      req_ch.valid <= 1'b0;
      while (tree_model.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("sent %0d symbols (%0d out of range), checked %0d results",
               symbols_sent, out_of_range_sent, tree_model.checked);
      $display("tree rebuilds %0d, node exchanges %0d, thresholds 2 and 65534 written",
               tree_model.rebuilds, tree_model.swaps_seen);
      if (tree_model.errors == 0) begin
         $display("** adaptive_huffman_model_update_core: PASSED **");
      end else begin
         $display("** adaptive_huffman_model_update_core: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== adaptive_huffman_model_update_core.f =====
design/ahm_pkg.sv
design/ahm_req_if.sv
design/ahm_rsp_if.sv
design/adaptive_huffman_model_update_core.sv
verif/adaptive_huffman_model_update_core_test.sv
